// ----- design/cswb_pkg.sv -----
`default_nettype none

package cswb_pkg;

    localparam int NUM_CH = 3;

    typedef logic [1:0]  channel_t;
    typedef logic [2:0]  cfg_index_t;
    typedef logic [1:0]  err_t;
    typedef logic [4:0]  step_cnt_t;
    typedef logic [15:0] word_t;
    typedef logic [7:0]  level_t;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    localparam channel_t CH_RED   = 2'd0;
    localparam channel_t CH_GREEN = 2'd1;
    localparam channel_t CH_BLUE  = 2'd2;
    localparam channel_t CH_NONE  = 2'd3;

    localparam err_t ERR_OK        = 2'd0;
    localparam err_t ERR_ZERO_PER  = 2'd1;
    localparam err_t ERR_ZERO_WREF = 2'd2;

    localparam cfg_index_t REG_TICK_RATE  = 3'd0;
    localparam cfg_index_t REG_RED_LOW    = 3'd1;
    localparam cfg_index_t REG_RED_HIGH   = 3'd2;
    localparam cfg_index_t REG_GREEN_LOW  = 3'd3;
    localparam cfg_index_t REG_GREEN_HIGH = 3'd4;
    localparam cfg_index_t REG_BLUE_LOW   = 3'd5;
    localparam cfg_index_t REG_BLUE_HIGH  = 3'd6;
    localparam cfg_index_t REG_UNUSED     = 3'd7;

    localparam word_t  TICK_RATE_RST = 16'd10000;
    localparam level_t WIN_LOW_RST   = 8'd100;
    localparam level_t WIN_HIGH_RST  = 8'd150;
    localparam level_t LEVEL_MAX     = 8'd255;

    localparam step_cnt_t FREQ_STEPS  = 5'd16;
    localparam step_cnt_t LEVEL_STEPS = 5'd8;

endpackage

`default_nettype wire

// ----- design/cswb_if.sv -----
`default_nettype none

interface cswb_in_if import cswb_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     opcode;
    channel_t channel;
    word_t    period;

    modport source (output valid, opcode, channel, period, input ready);
    modport sink   (input valid, opcode, channel, period, output ready);
endinterface

interface cswb_out_if import cswb_pkg::*; ();
    logic     valid;
    logic     ready;
    channel_t channel_out;
    word_t    frequency;
    level_t   level;
    logic     saturated;
    err_t     error_code;
    logic     in_window;

    modport source (output valid, channel_out, frequency, level, saturated, error_code,
                    in_window, input ready);
    modport sink   (input valid, channel_out, frequency, level, saturated, error_code,
                    in_window, output ready);
endinterface

interface cswb_cfg_if import cswb_pkg::*; ();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    word_t      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/color_sensor_white_balance_unit.sv -----
// A measure runs the shared 1-bit-per-cycle restoring divider for 16 steps, then, unless
// the reference is zero or the level saturates, 8 steps; a calibrate runs only the 16 steps;
// a zero period skips the divider. A new request is taken only while the block is idle.
// The output register lets the next request enter while a result waits.
// Reset (async, rst_n low): idle, no result, references, levels and mask zero,
// tick rate 10000, windows 100..150. Config port always ready.
`default_nettype none

module color_sensor_white_balance_unit import cswb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cswb_cfg_if.sink      cfg,
    cswb_in_if.sink       sample,
    cswb_out_if.source    result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV1  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV2  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]  state_reg, state_next;
    step_cnt_t   cnt_reg, cnt_next;

    word_t       tick_rate_reg;
    level_t      win_low_reg  [NUM_CH];
    level_t      win_high_reg [NUM_CH];
    word_t       wref_reg     [NUM_CH];
    level_t      last_level_reg [NUM_CH];
    logic [2:0]  mask_reg, mask_next;
    logic        wref_we, level_we;
    level_t      level_wdata;

    logic        op_reg, op_next;
    channel_t    ch_reg, ch_next;
    word_t       rem_reg, rem_next;
    word_t       dvd_reg, dvd_next;
    word_t       dvs_reg, dvs_next;
    word_t       q_reg, q_next;
    word_t       freq_reg, freq_next;
    level_t      level_reg, level_next;
    logic        sat_reg, sat_next;
    err_t        err_reg, err_next;

    logic        out_valid_reg, out_valid_next;
    channel_t    out_ch_reg;
    word_t       out_freq_reg;
    level_t      out_level_reg;
    logic        out_sat_reg;
    err_t        out_err_reg;
    logic        out_win_reg;
    logic        out_load;

    logic [16:0] r_sh;
    logic [16:0] r_diff;
    logic        fits;
    word_t       rem_step;
    word_t       q_step;
    logic [23:0] scaled;
    word_t       wref_sel;
    logic        win_match;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == ST_IDLE);
    assign out_load     = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    // shared restoring divider step
    assign r_sh     = {rem_reg, dvd_reg[15]};
    assign r_diff   = r_sh - {1'b0, dvs_reg};
    assign fits     = (r_sh >= {1'b0, dvs_reg});
    assign rem_step = fits ? r_diff[15:0] : r_sh[15:0];
    assign q_step   = {q_reg[14:0], fits};

    assign wref_sel = wref_reg[ch_reg];
    assign scaled   = {freq_reg, 8'h00} - {8'h00, freq_reg};

    always_comb
    begin
        win_match = (mask_reg == 3'b111);
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (last_level_reg[c] < win_low_reg[c] || last_level_reg[c] > win_high_reg[c])
                win_match = 1'b0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        ch_next     = ch_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        q_next      = q_reg;
        freq_next   = freq_reg;
        level_next  = level_reg;
        sat_next    = sat_reg;
        err_next    = err_reg;
        mask_next   = mask_reg;
        wref_we     = 1'b0;
        level_we    = 1'b0;
        level_wdata = q_step[7:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid && sample.channel != CH_NONE)
                begin
                    op_next    = sample.opcode;
                    ch_next    = sample.channel;
                    freq_next  = '0;
                    level_next = '0;
                    sat_next   = 1'b0;
                    err_next   = ERR_OK;
                    rem_next   = '0;
                    dvd_next   = tick_rate_reg;
                    dvs_next   = sample.period;
                    q_next     = '0;
                    cnt_next   = FREQ_STEPS;
                    if (sample.period == '0)
                    begin
                        err_next   = ERR_ZERO_PER;
                        state_next = ST_FIN;
                    end
                    else
                        state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[14:0], 1'b0};
                q_next   = q_step;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    freq_next  = q_step;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (op_reg == OP_CALIBRATE)
                begin
                    wref_we    = 1'b1;
                    state_next = ST_FIN;
                end
                else if (wref_sel == '0)
                begin
                    err_next   = ERR_ZERO_WREF;
                    state_next = ST_FIN;
                end
                else if (scaled >= {wref_sel, 8'h00})
                begin
                    level_next  = LEVEL_MAX;
                    sat_next    = 1'b1;
                    level_we    = 1'b1;
                    level_wdata = LEVEL_MAX;
                    mask_next   = mask_reg | (3'b001 << ch_reg);
                    state_next  = ST_FIN;
                end
                else
                begin
                    // quotient below 256: top 16 bits already below the divisor
                    rem_next   = scaled[23:8];
                    dvd_next   = {scaled[7:0], 8'h00};
                    dvs_next   = wref_sel;
                    q_next     = '0;
                    cnt_next   = LEVEL_STEPS;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[14:0], 1'b0};
                q_next   = q_step;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    level_next = q_step[7:0];
                    level_we   = 1'b1;
                    mask_next  = mask_reg | (3'b001 << ch_reg);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            tick_rate_reg <= TICK_RATE_RST;
            for (int c = 0; c < NUM_CH; c++)
            begin
                win_low_reg[c]    <= WIN_LOW_RST;
                win_high_reg[c]   <= WIN_HIGH_RST;
                wref_reg[c]       <= '0;
                last_level_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            if (wref_we)
                wref_reg[ch_reg] <= freq_reg;
            if (level_we)
                last_level_reg[ch_reg] <= level_wdata;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TICK_RATE:  tick_rate_reg   <= cfg.data;
                    REG_RED_LOW:    win_low_reg[0]  <= cfg.data[7:0];
                    REG_RED_HIGH:   win_high_reg[0] <= cfg.data[7:0];
                    REG_GREEN_LOW:  win_low_reg[1]  <= cfg.data[7:0];
                    REG_GREEN_HIGH: win_high_reg[1] <= cfg.data[7:0];
                    REG_BLUE_LOW:   win_low_reg[2]  <= cfg.data[7:0];
                    REG_BLUE_HIGH:  win_high_reg[2] <= cfg.data[7:0];
                    REG_UNUSED:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        q_reg     <= q_next;
        freq_reg  <= freq_next;
        level_reg <= level_next;
        sat_reg   <= sat_next;
        err_reg   <= err_next;
        if (out_load)
        begin
            out_ch_reg    <= ch_reg;
            out_freq_reg  <= freq_reg;
            out_level_reg <= level_reg;
            out_sat_reg   <= sat_reg;
            out_err_reg   <= err_reg;
            out_win_reg   <= win_match;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.channel_out = out_ch_reg;
    assign result.frequency   = out_freq_reg;
    assign result.level       = out_level_reg;
    assign result.saturated   = out_sat_reg;
    assign result.error_code  = out_err_reg;
    assign result.in_window   = out_win_reg;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result.valid)
        else $error("loaded result not presented");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && err_reg != ERR_OK) |-> (level_reg == '0 && !sat_reg))
        else $error("error result carries a level");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && sat_reg) |-> (level_reg == LEVEL_MAX))
        else $error("saturated level not at maximum");

    a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((mask_reg & $past(mask_reg)) == $past(mask_reg)))
        else $error("measured mask lost a channel");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (cnt_reg != '0))
        else $error("divider running with zero step count");
`endif

endmodule

`default_nettype wire

// ----- sim/cswb_checker.sv -----
`default_nettype none

module cswb_checker import cswb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cswb_cfg_if       cfg,
    cswb_in_if        sample,
    cswb_out_if       result,
    output int        failures,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        channel_t ch;
        word_t    freq;
        level_t   level;
        logic     sat;
        err_t     err;
        logic     match;
    } balance_t;

    balance_t balance_q[$];

    word_t  tick_rate_m;
    level_t win_low_m [NUM_CH];
    level_t win_high_m[NUM_CH];
    word_t  white_ref_m[NUM_CH];
    level_t last_level_m[NUM_CH];
    logic [NUM_CH-1:0] seen_m;
    int     fail_n;

    function automatic balance_t predict_balance(logic op, channel_t ch, word_t per);
        balance_t    r;
        logic [31:0] q;
        int          c;
        r       = '0;
        r.ch    = ch;
        r.err   = ERR_OK;
        if (per == '0)
        begin
            r.err = ERR_ZERO_PER;
        end
        else
        begin
            r.freq = tick_rate_m / per;
            if (op == OP_CALIBRATE)
            begin
                white_ref_m[ch] = r.freq;
            end
            else if (white_ref_m[ch] == '0)
            begin
                r.err = ERR_ZERO_WREF;
            end
            else
            begin
                q = (32'(r.freq) * 32'(LEVEL_MAX)) / 32'(white_ref_m[ch]);
                if (q > 32'(LEVEL_MAX))
                begin
                    q     = 32'(LEVEL_MAX);
                    r.sat = 1'b1;
                end
                r.level          = q[7:0];
                last_level_m[ch] = q[7:0];
                seen_m[ch]       = 1'b1;
            end
        end
        r.match = (seen_m == '1);
        for (c = 0; c < NUM_CH; c++)
        begin
            if (last_level_m[c] < win_low_m[c] || last_level_m[c] > win_high_m[c])
                r.match = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_n++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        balance_t want;
        int       c;
        if (!rst_n)
        begin
            tick_rate_m = TICK_RATE_RST;
            for (c = 0; c < NUM_CH; c++)
            begin
                win_low_m[c]    = WIN_LOW_RST;
                win_high_m[c]   = WIN_HIGH_RST;
                white_ref_m[c]  = '0;
                last_level_m[c] = '0;
            end
            seen_m = '0;
            fail_n = 0;
            balance_q.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (balance_q.size() == 0)
                begin
                    $error("result for channel %0d with no request outstanding",
                           result.channel_out);
                    fail_n++;
                end
                else
                begin
                    want = balance_q.pop_front();
                    check_field("channel_out", 16'(want.ch), 16'(result.channel_out));
                    check_field("frequency", want.freq, result.frequency);
                    check_field("level", 16'(want.level), 16'(result.level));
                    check_field("saturated", 16'(want.sat), 16'(result.saturated));
                    check_field("error_code", 16'(want.err), 16'(result.error_code));
                    check_field("in_window", 16'(want.match), 16'(result.in_window));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TICK_RATE:  tick_rate_m           = cfg.data;
                    REG_RED_LOW:    win_low_m[CH_RED]     = cfg.data[7:0];
                    REG_RED_HIGH:   win_high_m[CH_RED]    = cfg.data[7:0];
                    REG_GREEN_LOW:  win_low_m[CH_GREEN]   = cfg.data[7:0];
                    REG_GREEN_HIGH: win_high_m[CH_GREEN]  = cfg.data[7:0];
                    REG_BLUE_LOW:   win_low_m[CH_BLUE]    = cfg.data[7:0];
                    REG_BLUE_HIGH:  win_high_m[CH_BLUE]   = cfg.data[7:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready && sample.channel != CH_NONE)
                balance_q.push_back(predict_balance(sample.opcode, sample.channel,
                                                    sample.period));
            failures <= fail_n;
            pending  <= balance_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top import cswb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    bit   no_gaps;

    cswb_cfg_if cfg_bus();
    cswb_in_if  sample_bus();
    cswb_out_if result_bus();

    color_sensor_white_balance_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    cswb_checker balance_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .sample   (sample_bus),
        .result   (result_bus),
        .failures (fail_count),
        .pending  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result back-pressure: short stalls, rare long ones, occasional long open stretches
    initial
    begin
        int unsigned n;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_bus.ready <= 1'b1;
            n = ($urandom_range(9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
            repeat (n) @(posedge clk);
            n = idle_len();
            if (n != 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic issue(input logic op, input channel_t ch, input word_t per);
        int unsigned g;
        sample_bus.valid   <= 1'b1;
        sample_bus.opcode  <= op;
        sample_bus.channel <= ch;
        sample_bus.period  <= per;
        do @(posedge clk); while (sample_bus.ready !== 1'b1);
        g = no_gaps ? 0 : idle_len();
        if (g != 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // covers requests that produce no result, such as those for channel none
    task automatic settle();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input word_t val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    endtask

    task automatic program_windows(input int phase);
        word_t       tick;
        level_t      lo[NUM_CH];
        level_t      hi[NUM_CH];
        int unsigned c, mid, half, r;
        for (c = 0; c < NUM_CH; c++)
        begin
            case (phase)
                0:
                begin
                    lo[c] = 8'd0;
                    hi[c] = 8'd255;
                end
                1:
                begin
                    lo[c] = 8'd255;
                    hi[c] = 8'd255;
                end
                2:
                begin
                    lo[c] = 8'd0;
                    hi[c] = 8'd0;
                end
                default:
                begin
                    r    = $urandom_range(9);
                    mid  = $urandom_range(60, 220);
                    half = $urandom_range(5, 60);
                    lo[c] = (mid > half) ? level_t'(mid - half) : 8'd0;
                    hi[c] = (mid + half > 255) ? 8'd255 : level_t'(mid + half);
                    if (r == 0)
                    begin
                        lo[c] = 8'd0;
                        hi[c] = 8'd255;
                    end
                    else if (r == 1)
                    begin
                        lo[c] = level_t'(mid + 10);
                        hi[c] = level_t'(mid - 10);
                    end
                end
            endcase
        end
        case (phase)
            0:       tick = 16'hFFFF;
            1:       tick = 16'd1;
            2:       tick = 16'd0;
            default:
            begin
                r = $urandom_range(99);
                if (r < 15)
                    tick = 16'hFFFF;
                else if (r < 25)
                    tick = word_t'($urandom_range(1, 255));
                else
                    tick = word_t'($urandom_range(256, 65535));
            end
        endcase
        write_reg(REG_TICK_RATE,  tick);
        write_reg(REG_RED_LOW,    {8'($urandom), lo[CH_RED]});
        write_reg(REG_RED_HIGH,   {8'($urandom), hi[CH_RED]});
        write_reg(REG_GREEN_LOW,  {8'($urandom), lo[CH_GREEN]});
        write_reg(REG_GREEN_HIGH, {8'($urandom), hi[CH_GREEN]});
        write_reg(REG_BLUE_LOW,   {8'($urandom), lo[CH_BLUE]});
        write_reg(REG_BLUE_HIGH,  {8'($urandom), hi[CH_BLUE]});
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic word_t white_period();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return word_t'($urandom_range(1, 64));
        if (r < 85)
            return word_t'($urandom_range(65, 4000));
        return word_t'($urandom_range(1, 65535));
    endfunction

    // periods scaled from the white period land levels around the windows
    function automatic word_t sensor_period(input word_t white);
        int unsigned r, p;
        r = $urandom_range(99);
        if (r < 3)
            return 16'd0;
        if (r < 20)
            return word_t'($urandom);
        p = (int'(white) * $urandom_range(150, 900)) / 256;
        if (p == 0)
            p = 1;
        if (p > 65535)
            p = 65535;
        return word_t'(p);
    endfunction

    task automatic run_random(input int unsigned count);
        word_t       white[NUM_CH];
        int unsigned done_n, k, reps;
        channel_t    ch;
        done_n = 0;
        while (done_n < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                for (k = 0; k < NUM_CH; k++)
                begin
                    white[k] = white_period();
                    issue(OP_CALIBRATE, channel_t'(k), white[k]);
                end
                reps = $urandom_range(3, 12);
                for (k = 0; k < reps; k++)
                begin
                    ch = channel_t'($urandom_range(NUM_CH - 1));
                    issue(OP_MEASURE, ch, sensor_period(white[ch]));
                end
                done_n += NUM_CH + reps;
            end
            else
            begin
                ch = channel_t'($urandom_range(3));
                issue($urandom_range(1) ? OP_CALIBRATE : OP_MEASURE, ch,
                      ($urandom_range(19) == 0) ? 16'd0 : word_t'($urandom));
                if (ch != CH_NONE)
                    done_n++;
            end
        end
    endtask

    initial
    begin
        int phase;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= REG_TICK_RATE;
        cfg_bus.data       <= '0;
        sample_bus.valid   <= 1'b0;
        sample_bus.opcode  <= OP_MEASURE;
        sample_bus.channel <= CH_RED;
        sample_bus.period  <= '0;
        no_gaps = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // reset settings: tick rate 10000, windows 100..150
        issue(OP_MEASURE,   CH_RED,   16'd100);
        issue(OP_MEASURE,   CH_GREEN, 16'd0);
        issue(OP_CALIBRATE, CH_RED,   16'd0);
        issue(OP_MEASURE,   CH_NONE,  16'd5);
        issue(OP_CALIBRATE, CH_RED,   16'd100);
        issue(OP_CALIBRATE, CH_GREEN, 16'd50);
        issue(OP_CALIBRATE, CH_BLUE,  16'd1);
        issue(OP_MEASURE,   CH_RED,   16'd100);
        issue(OP_MEASURE,   CH_RED,   16'd50);
        issue(OP_MEASURE,   CH_GREEN, 16'd80);
        issue(OP_MEASURE,   CH_BLUE,  16'hFFFF);
        issue(OP_MEASURE,   CH_BLUE,  16'd1);
        issue(OP_MEASURE,   CH_RED,   16'd200);
        issue(OP_MEASURE,   CH_GREEN, 16'd100);
        issue(OP_MEASURE,   CH_BLUE,  16'd2);
        issue(OP_CALIBRATE, CH_RED,   16'hFFFF);
        issue(OP_MEASURE,   CH_RED,   16'd100);
        issue(OP_CALIBRATE, CH_NONE,  16'hFFFF);
        settle();

        for (phase = 0; phase < 10; phase++)
        begin
            program_windows(phase);
            no_gaps = ($urandom_range(3) == 0);
            run_random(145);
            settle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
